### src/bta_pkg.sv
// Shared constants, types and helper functions of the boundary-tag heap allocator.
package bta_pkg;

  localparam int unsigned HEAP_UNITS  = 4096;
  localparam int unsigned ADDR_W      = $clog2(HEAP_UNITS);
  localparam int unsigned SIZE_W      = ADDR_W + 1;
  localparam int unsigned UNIT_BYTES  = 32;
  localparam int unsigned UNIT_SHIFT  = $clog2(UNIT_BYTES);
  localparam int unsigned BYTES_W     = 18;
  localparam int unsigned NEED_W      = 14;
  localparam int unsigned ACC_W       = 25;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned IN_DATA_W   = 32;
  localparam int unsigned OUT_DATA_W  = 56;
  localparam int unsigned PAGE_RESET  = 128;
  localparam int unsigned FIRST_BLOCK = 3;
  localparam int unsigned SENTINEL_SZ = 2;
  localparam int unsigned MIN_SPLIT   = 2;

  localparam logic [PADDR_W-1:0] REG_PAGE_UNITS = 3'd0;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 3'd0,
    CMD_FREE    = 3'd1,
    CMD_REALLOC = 3'd2,
    CMD_QUERY   = 3'd3,
    CMD_REINIT  = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_IGNORED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    RC_FREE,
    RC_GROW,
    RC_REALLOC
  } rel_ctx_e;

  typedef enum logic {
    UC_TAKE,
    UC_REL
  } unl_ctx_e;

  typedef enum logic [5:0] {
    S_INIT, S_IDLE, S_V_HDR, S_V_FTR, S_A_CHK, S_G_START, S_G_W2, S_G_FIT, S_G_CHK,
    S_T_START, S_T_WF, S_T_S2, S_T_S3, S_T_S4, S_T_ROV, S_T_ROV2,
    S_UL1, S_UL2, S_UL3, S_UL4, S_A_RET, S_A_FAIL,
    S_R_START, S_R_N, S_R_L, S_R_I1, S_R_I2, S_R_I3, S_R_I4, S_R_I5, S_R_I6,
    S_R_M1, S_R_M2, S_R_M3, S_R_M4, S_R_RCHK, S_R_R1, S_R_R2, S_R_R3,
    S_R_FIN1, S_R_FIN2, S_Q_CHK, S_Q_FIN, S_DONE
  } state_e;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              used;
  } tag_t;

  typedef struct packed {
    logic [ADDR_W-1:0] nxt;
    logic [ADDR_W-1:0] prv;
  } link_t;

  // Units needed for a payload: whole units rounded up plus header and footer.
  function automatic logic [NEED_W-1:0] units_for(input logic [BYTES_W-1:0] bytes);
    logic [BYTES_W:0] sum;
    sum = {1'b0, bytes} + (BYTES_W+1)'(UNIT_BYTES - 1);
    return NEED_W'(sum >> UNIT_SHIFT) + NEED_W'(SENTINEL_SZ);
  endfunction

endpackage

### src/boundary_tag_heap_allocator.sv
// Top level of the boundary-tag heap allocator: command sequencer around the tag and link memories.
//
// The heap lives in two single-port-per-direction memories of 4096 entries: one holds each
// unit's boundary tag (size in units and a used flag), the other the free-list links. A
// sequencer serves one request at a time, reading an entry, checking the registered read data
// and writing it back. Alloc walks the free list next-fit from the rover, one block at a time,
// then takes the block (split or whole, with unlinking); if the walk wraps it grows the heap
// and frees the new region. Free merges the block with any free neighbor on either side.
// Realloc is a validation plus either an immediate answer or alloc followed by free. The
// free-byte query walks the free list block by block. Reinitialize clears both memories, one
// entry a cycle, and rewrites the sentinel and guard tags. After reset the block writes the
// sentinel and guard tags before it takes its first request. A finished result waits in an
// output register; the sequencer stays done until that register is free or being read, and
// takes the next request once idle. page_units is written through the APB port at byte
// address 0; the user must write it only while the block is idle, the block does not enforce it.
module boundary_tag_heap_allocator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [17:0] size_bytes, [29:18] addr, [31:30] zero
  input  logic [bta_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [2:0] cmd
  input  logic [bta_pkg::CMD_W-1:0]          s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [11:0] result_addr, [13:12] status, [31:14] copy_bytes, [49:32] free_bytes, [55:50] zero
  output logic [bta_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bta_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int unsigned AW = bta_pkg::ADDR_W;
  localparam int unsigned SW = bta_pkg::SIZE_W;
  localparam int unsigned NW = bta_pkg::NEED_W;
  localparam int unsigned BW = bta_pkg::BYTES_W;
  localparam int unsigned CW = bta_pkg::ACC_W;

  bta_pkg::state_e   state_q, state_d;
  logic [2:0]        cmd_q, cmd_d;
  logic [BW-1:0]     size_q, size_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [NW-1:0]     need_q, need_d;
  logic [AW-1:0]     b_q, b_d;
  logic [SW-1:0]     n_q, n_d;
  logic [SW-1:0]     s_q, s_d;
  logic [SW-1:0]     os_q, os_d;
  logic [AW-1:0]     p_q, p_d;
  logic [AW-1:0]     x_q, x_d;
  logic [AW-1:0]     cnt_q, cnt_d;
  logic [AW-1:0]     last_q, last_d;
  logic              reinit_q, reinit_d;
  logic [AW-1:0]     ab_q, ab_d;
  logic [AW-1:0]     rover_q, rover_d;
  logic [SW-1:0]     heap_top_q, heap_top_d;
  logic [SW-1:0]     page_q;
  logic [AW-1:0]     res_q, res_d;
  logic [1:0]        status_q, status_d;
  logic [BW-1:0]     copy_q, copy_d;
  logic [BW-1:0]     fb_q, fb_d;
  logic [CW-1:0]     acc_q, acc_d;
  bta_pkg::rel_ctx_e rctx_q, rctx_d;
  bta_pkg::unl_ctx_e uctx_q, uctx_d;
  logic              out_valid_q;
  logic [bta_pkg::OUT_DATA_W-1:0] out_data_q;

  // Heap memories: synchronous read with registered data, one write per cycle.
  bta_pkg::tag_t  tag_mem  [bta_pkg::HEAP_UNITS];
  bta_pkg::link_t link_mem [bta_pkg::HEAP_UNITS];
  bta_pkg::tag_t  tag_rd_q;
  bta_pkg::link_t link_rd_q;
  logic           tag_we, tag_re, link_we, link_re;
  logic [AW-1:0]  tag_wa, tag_ra, link_wa, link_ra;
  bta_pkg::tag_t  tag_wd;
  bta_pkg::link_t link_wd;

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[tag_wa] <= tag_wd;
    end
    if (tag_re) begin
      tag_rd_q <= tag_mem[tag_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (link_re) begin
      link_rd_q <= link_mem[link_ra];
    end
  end

  // Input fields.
  logic [2:0]    in_cmd;
  logic [BW-1:0] in_size;
  logic [AW-1:0] in_addr, in_blk;
  logic          in_acc;
  assign in_cmd  = s_axis_tuser;
  assign in_size = s_axis_tdata[BW-1:0];
  assign in_addr = s_axis_tdata[BW+AW-1:BW];
  assign in_blk  = in_addr - AW'(1);
  assign s_axis_tready = (state_q == bta_pkg::S_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Shared decisions of the sequencer.
  logic          in_is_alloc, v_pre_bad, vhdr_bad, vftr_bad, keep_blk;
  logic          fit_ok, walk_end, whole, grow_bad, left_oob, right_oob, is_move;
  logic [AW-1:0] lft, e_idx, vftr, tftr, fend, rend;
  logic [NW:0]   e_sum;
  logic [SW-1:0] need_s, r_sz, ht_gap;
  logic [NW-1:0] nu, room;
  logic [BW-1:0] ob_bytes;

  assign in_is_alloc = (in_cmd == bta_pkg::CMD_ALLOC) ||
                       ((in_cmd == bta_pkg::CMD_REALLOC) && (in_addr == '0));
  assign v_pre_bad = (in_blk < AW'(bta_pkg::FIRST_BLOCK)) || ({1'b0, in_blk} >= heap_top_q);
  assign ht_gap    = heap_top_q - {1'b0, b_q};
  assign vhdr_bad  = !tag_rd_q.used || (tag_rd_q.size < SW'(bta_pkg::SENTINEL_SZ)) ||
                     (tag_rd_q.size > ht_gap);
  assign vftr      = b_q + tag_rd_q.size[AW-1:0] - AW'(1);
  assign vftr_bad  = !tag_rd_q.used || (tag_rd_q.size != s_q);
  assign keep_blk  = (size_q != '0) && ({1'b0, s_q} >= need_q);
  assign fit_ok    = !tag_rd_q.used && ({1'b0, tag_rd_q.size} >= need_q);
  assign walk_end  = (link_rd_q.nxt == rover_q) || (cnt_q == AW'(bta_pkg::HEAP_UNITS - 1));
  assign need_s    = need_q[SW-1:0];
  assign whole     = ({2'b00, s_q} < ({1'b0, need_q} + (NW+1)'(bta_pkg::MIN_SPLIT)));
  assign r_sz      = s_q - need_s;
  assign tftr      = b_q + s_q[AW-1:0] - AW'(1);
  assign nu        = (need_q > {1'b0, page_q}) ? need_q : {1'b0, page_q};
  assign room      = NW'(bta_pkg::HEAP_UNITS) - {1'b0, heap_top_q};
  assign grow_bad  = (heap_top_q > SW'(bta_pkg::HEAP_UNITS)) || (nu > room);
  assign lft       = b_q - AW'(1);
  assign left_oob  = ({1'b0, lft} >= heap_top_q);
  assign e_sum     = {3'b000, b_q} + {2'b00, n_q};
  assign e_idx     = e_sum[AW-1:0];
  assign right_oob = (e_sum >= {2'b00, heap_top_q});
  assign fend      = b_q + n_q[AW-1:0] - AW'(1);
  assign rend      = b_q + r_sz[AW-1:0] - AW'(1);
  assign is_move   = (cmd_q == bta_pkg::CMD_REALLOC) && (addr_q != '0);
  assign ob_bytes  = BW'(os_q - SW'(bta_pkg::SENTINEL_SZ)) << bta_pkg::UNIT_SHIFT;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      bta_pkg::S_INIT: begin
        if (cnt_q == last_q) begin
          state_d = reinit_q ? bta_pkg::S_DONE : bta_pkg::S_IDLE;
        end
      end
      bta_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_is_alloc) begin
            state_d = bta_pkg::S_A_CHK;
          end else begin
            case (in_cmd)
              bta_pkg::CMD_FREE, bta_pkg::CMD_REALLOC: begin
                state_d = (in_addr == '0 || v_pre_bad) ? bta_pkg::S_DONE : bta_pkg::S_V_HDR;
              end
              bta_pkg::CMD_QUERY:  state_d = bta_pkg::S_Q_CHK;
              bta_pkg::CMD_REINIT: state_d = bta_pkg::S_INIT;
              default:             state_d = bta_pkg::S_DONE;
            endcase
          end
        end
      end
      bta_pkg::S_V_HDR: state_d = vhdr_bad ? bta_pkg::S_DONE : bta_pkg::S_V_FTR;
      bta_pkg::S_V_FTR: begin
        if (vftr_bad) begin
          state_d = bta_pkg::S_DONE;
        end else if (cmd_q == bta_pkg::CMD_FREE) begin
          state_d = bta_pkg::S_R_START;
        end else if (keep_blk) begin
          state_d = bta_pkg::S_DONE;
        end else begin
          state_d = bta_pkg::S_A_CHK;
        end
      end
      bta_pkg::S_A_CHK: begin
        if (fit_ok) begin
          state_d = bta_pkg::S_T_START;
        end else if (walk_end) begin
          state_d = bta_pkg::S_G_START;
        end
      end
      bta_pkg::S_G_START: state_d = grow_bad ? bta_pkg::S_A_FAIL : bta_pkg::S_G_W2;
      bta_pkg::S_G_W2:    state_d = bta_pkg::S_R_START;
      bta_pkg::S_G_FIT:   state_d = bta_pkg::S_G_CHK;
      bta_pkg::S_G_CHK:   state_d = fit_ok ? bta_pkg::S_T_START : bta_pkg::S_A_FAIL;
      bta_pkg::S_T_START: state_d = whole ? bta_pkg::S_T_WF : bta_pkg::S_T_S2;
      bta_pkg::S_T_WF:    state_d = bta_pkg::S_UL1;
      bta_pkg::S_T_S2:    state_d = bta_pkg::S_T_S3;
      bta_pkg::S_T_S3:    state_d = bta_pkg::S_T_S4;
      bta_pkg::S_T_S4:    state_d = bta_pkg::S_T_ROV;
      bta_pkg::S_T_ROV:   state_d = bta_pkg::S_T_ROV2;
      bta_pkg::S_T_ROV2:  state_d = bta_pkg::S_A_RET;
      bta_pkg::S_UL1:     state_d = bta_pkg::S_UL2;
      bta_pkg::S_UL2:     state_d = bta_pkg::S_UL3;
      bta_pkg::S_UL3:     state_d = bta_pkg::S_UL4;
      bta_pkg::S_UL4: begin
        state_d = (uctx_q == bta_pkg::UC_TAKE) ? bta_pkg::S_T_ROV : bta_pkg::S_R_R2;
      end
      bta_pkg::S_A_RET: begin
        state_d = (ab_q != '0 && is_move) ? bta_pkg::S_R_START : bta_pkg::S_DONE;
      end
      bta_pkg::S_A_FAIL:  state_d = bta_pkg::S_DONE;
      bta_pkg::S_R_START: state_d = bta_pkg::S_R_N;
      bta_pkg::S_R_N:     state_d = left_oob ? bta_pkg::S_R_I1 : bta_pkg::S_R_L;
      bta_pkg::S_R_L:     state_d = tag_rd_q.used ? bta_pkg::S_R_I1 : bta_pkg::S_R_M1;
      bta_pkg::S_R_I1:    state_d = bta_pkg::S_R_I2;
      bta_pkg::S_R_I2:    state_d = bta_pkg::S_R_I3;
      bta_pkg::S_R_I3:    state_d = bta_pkg::S_R_I4;
      bta_pkg::S_R_I4:    state_d = bta_pkg::S_R_I5;
      bta_pkg::S_R_I5:    state_d = bta_pkg::S_R_I6;
      bta_pkg::S_R_I6:    state_d = bta_pkg::S_R_RCHK;
      bta_pkg::S_R_M1:    state_d = bta_pkg::S_R_M2;
      bta_pkg::S_R_M2:    state_d = bta_pkg::S_R_M3;
      bta_pkg::S_R_M3:    state_d = bta_pkg::S_R_M4;
      bta_pkg::S_R_M4:    state_d = bta_pkg::S_R_RCHK;
      bta_pkg::S_R_RCHK:  state_d = right_oob ? bta_pkg::S_R_FIN1 : bta_pkg::S_R_R1;
      bta_pkg::S_R_R1:    state_d = tag_rd_q.used ? bta_pkg::S_R_FIN1 : bta_pkg::S_UL1;
      bta_pkg::S_R_R2:    state_d = bta_pkg::S_R_R3;
      bta_pkg::S_R_R3:    state_d = bta_pkg::S_R_FIN1;
      bta_pkg::S_R_FIN1:  state_d = bta_pkg::S_R_FIN2;
      bta_pkg::S_R_FIN2: begin
        state_d = (rctx_q == bta_pkg::RC_GROW) ? bta_pkg::S_G_FIT : bta_pkg::S_DONE;
      end
      bta_pkg::S_Q_CHK:   state_d = walk_end ? bta_pkg::S_Q_FIN : bta_pkg::S_Q_CHK;
      bta_pkg::S_Q_FIN:   state_d = bta_pkg::S_DONE;
      bta_pkg::S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = bta_pkg::S_IDLE;
        end
      end
      default: state_d = bta_pkg::S_IDLE;
    endcase
  end

  // Datapath, register updates and memory ports.
  always_comb begin
    cmd_d      = cmd_q;
    size_d     = size_q;
    addr_d     = addr_q;
    need_d     = need_q;
    b_d        = b_q;
    n_d        = n_q;
    s_d        = s_q;
    os_d       = os_q;
    p_d        = p_q;
    x_d        = x_q;
    cnt_d      = cnt_q;
    last_d     = last_q;
    reinit_d   = reinit_q;
    ab_d       = ab_q;
    rover_d    = rover_q;
    heap_top_d = heap_top_q;
    res_d      = res_q;
    status_d   = status_q;
    copy_d     = copy_q;
    fb_d       = fb_q;
    acc_d      = acc_q;
    rctx_d     = rctx_q;
    uctx_d     = uctx_q;
    tag_we     = 1'b0;
    tag_wa     = b_q;
    tag_wd     = '0;
    tag_re     = 1'b0;
    tag_ra     = b_q;
    link_we    = 1'b0;
    link_wa    = b_q;
    link_wd    = '0;
    link_re    = 1'b0;
    link_ra    = b_q;
    case (state_q)
      bta_pkg::S_INIT: begin
        // Sentinel block at units 0 and 1, used guard tag at unit 2, all else cleared.
        tag_we  = 1'b1;
        tag_wa  = cnt_q;
        link_we = 1'b1;
        link_wa = cnt_q;
        if (cnt_q < AW'(bta_pkg::SENTINEL_SZ)) begin
          tag_wd = '{size: SW'(bta_pkg::SENTINEL_SZ), used: 1'b1};
        end else if (cnt_q == AW'(bta_pkg::SENTINEL_SZ)) begin
          tag_wd = '{size: '0, used: 1'b1};
        end
        cnt_d = cnt_q + AW'(1);
      end
      bta_pkg::S_IDLE: begin
        if (in_acc) begin
          cmd_d    = in_cmd;
          size_d   = in_size;
          addr_d   = in_addr;
          need_d   = bta_pkg::units_for(in_size);
          res_d    = '0;
          status_d = bta_pkg::ST_OK;
          copy_d   = '0;
          fb_d     = '0;
          cnt_d    = '0;
          acc_d    = '0;
          if (in_is_alloc || in_cmd == bta_pkg::CMD_QUERY) begin
            b_d     = rover_q;
            tag_re  = 1'b1;
            tag_ra  = rover_q;
            link_re = 1'b1;
            link_ra = rover_q;
          end else if (in_cmd == bta_pkg::CMD_FREE || in_cmd == bta_pkg::CMD_REALLOC) begin
            if (in_addr == '0 || v_pre_bad) begin
              status_d = bta_pkg::ST_IGNORED;
            end else begin
              b_d    = in_blk;
              tag_re = 1'b1;
              tag_ra = in_blk;
            end
          end else if (in_cmd == bta_pkg::CMD_REINIT) begin
            rover_d    = '0;
            heap_top_d = SW'(bta_pkg::FIRST_BLOCK);
            last_d     = AW'(bta_pkg::HEAP_UNITS - 1);
            reinit_d   = 1'b1;
          end
        end
      end
      bta_pkg::S_V_HDR: begin
        if (vhdr_bad) begin
          status_d = bta_pkg::ST_IGNORED;
        end else begin
          s_d    = tag_rd_q.size;
          tag_re = 1'b1;
          tag_ra = vftr;
        end
      end
      bta_pkg::S_V_FTR: begin
        if (vftr_bad) begin
          status_d = bta_pkg::ST_IGNORED;
        end else if (cmd_q == bta_pkg::CMD_FREE) begin
          rctx_d = bta_pkg::RC_FREE;
        end else if (keep_blk) begin
          res_d = addr_q;
        end else begin
          // Moving realloc: remember the old size, then search from the rover.
          os_d    = s_q;
          b_d     = rover_q;
          cnt_d   = '0;
          tag_re  = 1'b1;
          tag_ra  = rover_q;
          link_re = 1'b1;
          link_ra = rover_q;
        end
      end
      bta_pkg::S_A_CHK: begin
        if (fit_ok) begin
          s_d = tag_rd_q.size;
          p_d = link_rd_q.prv;
          x_d = link_rd_q.nxt;
        end else if (!walk_end) begin
          b_d     = link_rd_q.nxt;
          cnt_d   = cnt_q + AW'(1);
          tag_re  = 1'b1;
          tag_ra  = link_rd_q.nxt;
          link_re = 1'b1;
          link_ra = link_rd_q.nxt;
        end
      end
      bta_pkg::S_G_START: begin
        if (!grow_bad) begin
          b_d    = heap_top_q[AW-1:0];
          n_d    = nu[SW-1:0];
          tag_we = 1'b1;
          tag_wa = heap_top_q[AW-1:0];
          tag_wd = '{size: nu[SW-1:0], used: 1'b1};
        end
      end
      bta_pkg::S_G_W2: begin
        tag_we     = 1'b1;
        tag_wa     = fend;
        tag_wd     = '{size: n_q, used: 1'b1};
        heap_top_d = heap_top_q + n_q;
        rctx_d     = bta_pkg::RC_GROW;
      end
      bta_pkg::S_G_FIT: begin
        b_d     = rover_q;
        tag_re  = 1'b1;
        tag_ra  = rover_q;
        link_re = 1'b1;
        link_ra = rover_q;
      end
      bta_pkg::S_G_CHK: begin
        if (fit_ok) begin
          s_d = tag_rd_q.size;
          p_d = link_rd_q.prv;
          x_d = link_rd_q.nxt;
        end
      end
      bta_pkg::S_T_START: begin
        tag_we = 1'b1;
        if (whole) begin
          // Take the block whole: mark header and footer used, then unlink it.
          tag_wd = '{size: s_q, used: 1'b1};
          tag_re = 1'b1;
          tag_ra = tftr;
          uctx_d = bta_pkg::UC_TAKE;
        end else begin
          tag_wd = '{size: r_sz, used: 1'b0};
        end
      end
      bta_pkg::S_T_WF: begin
        tag_we = 1'b1;
        tag_wa = tftr;
        tag_wd = '{size: tag_rd_q.size, used: 1'b1};
      end
      bta_pkg::S_T_S2: begin
        tag_we = 1'b1;
        tag_wa = rend;
        tag_wd = '{size: r_sz, used: 1'b0};
        b_d    = b_q + r_sz[AW-1:0];
        n_d    = need_s;
      end
      bta_pkg::S_T_S3: begin
        tag_we = 1'b1;
        tag_wd = '{size: n_q, used: 1'b1};
      end
      bta_pkg::S_T_S4: begin
        tag_we = 1'b1;
        tag_wa = fend;
        tag_wd = '{size: n_q, used: 1'b1};
      end
      bta_pkg::S_T_ROV: begin
        link_re = 1'b1;
      end
      bta_pkg::S_T_ROV2: begin
        if (rover_q == b_q) begin
          rover_d = link_rd_q.prv;
        end
        ab_d = b_q;
      end
      bta_pkg::S_UL1: begin
        link_re = 1'b1;
        link_ra = p_q;
      end
      bta_pkg::S_UL2: begin
        link_we = 1'b1;
        link_wa = p_q;
        link_wd = '{nxt: x_q, prv: link_rd_q.prv};
      end
      bta_pkg::S_UL3: begin
        link_re = 1'b1;
        link_ra = x_q;
      end
      bta_pkg::S_UL4: begin
        link_we = 1'b1;
        link_wa = x_q;
        link_wd = '{nxt: link_rd_q.nxt, prv: p_q};
      end
      bta_pkg::S_A_RET: begin
        if (ab_q == '0) begin
          status_d = bta_pkg::ST_OOM;
        end else begin
          res_d = ab_q + AW'(1);
          if (is_move) begin
            copy_d = (ob_bytes < size_q) ? ob_bytes : size_q;
            b_d    = addr_q - AW'(1);
            rctx_d = bta_pkg::RC_REALLOC;
          end
        end
      end
      bta_pkg::S_A_FAIL: begin
        status_d = bta_pkg::ST_OOM;
        res_d    = '0;
      end
      bta_pkg::S_R_START: begin
        tag_re = 1'b1;
      end
      bta_pkg::S_R_N: begin
        n_d = tag_rd_q.size;
        if (!left_oob) begin
          tag_re = 1'b1;
          tag_ra = lft;
        end
      end
      bta_pkg::S_R_L: begin
        s_d = tag_rd_q.size;
      end
      bta_pkg::S_R_I1: begin
        link_re = 1'b1;
        link_ra = rover_q;
      end
      bta_pkg::S_R_I2: begin
        x_d     = link_rd_q.nxt;
        link_we = 1'b1;
        link_wd = '{nxt: link_rd_q.nxt, prv: rover_q};
      end
      bta_pkg::S_R_I3: begin
        link_re = 1'b1;
        link_ra = x_q;
      end
      bta_pkg::S_R_I4: begin
        link_we = 1'b1;
        link_wa = x_q;
        link_wd = '{nxt: link_rd_q.nxt, prv: b_q};
      end
      bta_pkg::S_R_I5: begin
        link_re = 1'b1;
        link_ra = rover_q;
      end
      bta_pkg::S_R_I6: begin
        link_we = 1'b1;
        link_wa = rover_q;
        link_wd = '{nxt: b_q, prv: link_rd_q.prv};
      end
      bta_pkg::S_R_M1: begin
        // Merge with the free block on the left.
        tag_we = 1'b1;
        tag_wd = '{size: n_q, used: 1'b0};
        b_d    = b_q - s_q[AW-1:0];
      end
      bta_pkg::S_R_M2: begin
        tag_re = 1'b1;
      end
      bta_pkg::S_R_M3: begin
        n_d    = n_q + tag_rd_q.size;
        tag_we = 1'b1;
        tag_wd = '{size: n_q + tag_rd_q.size, used: 1'b0};
      end
      bta_pkg::S_R_M4: begin
        tag_we = 1'b1;
        tag_wa = fend;
        tag_wd = '{size: n_q, used: 1'b0};
      end
      bta_pkg::S_R_RCHK: begin
        if (!right_oob) begin
          tag_re  = 1'b1;
          tag_ra  = e_idx;
          link_re = 1'b1;
          link_ra = e_idx;
        end
      end
      bta_pkg::S_R_R1: begin
        if (!tag_rd_q.used) begin
          s_d    = tag_rd_q.size;
          p_d    = link_rd_q.prv;
          x_d    = link_rd_q.nxt;
          uctx_d = bta_pkg::UC_REL;
        end
      end
      bta_pkg::S_R_R2: begin
        tag_we = 1'b1;
        tag_wa = fend;
        tag_wd = '{size: n_q, used: 1'b0};
      end
      bta_pkg::S_R_R3: begin
        tag_we = 1'b1;
        tag_wa = e_idx;
        tag_wd = '{size: s_q, used: 1'b0};
        n_d    = n_q + s_q;
      end
      bta_pkg::S_R_FIN1: begin
        tag_we = 1'b1;
        tag_wd = '{size: n_q, used: 1'b0};
      end
      bta_pkg::S_R_FIN2: begin
        tag_we  = 1'b1;
        tag_wa  = fend;
        tag_wd  = '{size: n_q, used: 1'b0};
        rover_d = b_q;
      end
      bta_pkg::S_Q_CHK: begin
        if (!tag_rd_q.used) begin
          acc_d = acc_q + CW'(tag_rd_q.size);
        end
        if (!walk_end) begin
          cnt_d   = cnt_q + AW'(1);
          tag_re  = 1'b1;
          tag_ra  = link_rd_q.nxt;
          link_re = 1'b1;
          link_ra = link_rd_q.nxt;
        end
      end
      bta_pkg::S_Q_FIN: begin
        // Units times unit bytes, saturated to the field width.
        if (acc_q >= CW'(1 << (BW - bta_pkg::UNIT_SHIFT))) begin
          fb_d = '1;
        end else begin
          fb_d = BW'(acc_q) << bta_pkg::UNIT_SHIFT;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= bta_pkg::S_INIT;
      cnt_q      <= '0;
      last_q     <= AW'(bta_pkg::SENTINEL_SZ);
      reinit_q   <= 1'b0;
      rover_q    <= '0;
      heap_top_q <= SW'(bta_pkg::FIRST_BLOCK);
      rctx_q     <= bta_pkg::RC_FREE;
      uctx_q     <= bta_pkg::UC_TAKE;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      last_q     <= last_d;
      reinit_q   <= (state_q == bta_pkg::S_INIT && cnt_q == last_q) ? 1'b0 : reinit_d;
      rover_q    <= rover_d;
      heap_top_q <= heap_top_d;
      rctx_q     <= rctx_d;
      uctx_q     <= uctx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    size_q   <= size_d;
    addr_q   <= addr_d;
    need_q   <= need_d;
    b_q      <= b_d;
    n_q      <= n_d;
    s_q      <= s_d;
    os_q     <= os_d;
    p_q      <= p_d;
    x_q      <= x_d;
    ab_q     <= ab_d;
    res_q    <= res_d;
    status_q <= status_d;
    copy_q   <= copy_d;
    fb_q     <= fb_d;
    acc_q    <= acc_d;
  end

  // Result register: loaded when the request finishes, held until taken.
  logic out_load;
  assign out_load = (state_q == bta_pkg::S_DONE) && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {6'b000000, fb_q, copy_q, status_q, res_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Configuration register.
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == bta_pkg::REG_PAGE_UNITS);
  assign pready = 1'b1;
  assign prdata = (paddr == bta_pkg::REG_PAGE_UNITS) ? {19'd0, page_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q <= SW'(bta_pkg::PAGE_RESET);
    end else if (cfg_wr) begin
      page_q <= pwdata[SW-1:0];
    end
  end

endmodule

### dv/tb_boundary_tag_heap_allocator.sv
// Self-checking testbench for the boundary-tag heap allocator: directed table, then random traffic.
module tb_boundary_tag_heap_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import bta_pkg::*;

  // Commands 5 to 7 are not decoded; the block must answer them with an all-zero result.
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam int unsigned MAX_BYTES  = 131072;
  localparam int unsigned STALL_MAX  = 30000;
  localparam int unsigned SETTLE     = 40;
  localparam int unsigned PHASE_REQS = 620;
  localparam int unsigned PRINT_CAP  = 100;

  typedef struct packed {
    logic [ADDR_W-1:0]  ra;
    logic [STATUS_W-1:0] st;
    logic [BYTES_W-1:0] cp;
    logic [BYTES_W-1:0] fb;
  } heap_answer_t;

  // One row of the directed table. A nonzero back takes the address from the answer of the
  // row that many rows earlier; typed rows carry their answer literally.
  typedef struct {
    logic [CMD_W-1:0] op;
    int unsigned      sz;
    int unsigned      ad;
    int unsigned      back;
    bit               typed;
    heap_answer_t     ans;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [CMD_W-1:0]      s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  boundary_tag_heap_allocator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the heap: per-unit links and boundary tags, plus a map of the units that
  // have ever been written, so that random addresses never make the block read junk.
  int unsigned  link_nx [HEAP_UNITS];
  int unsigned  link_pv [HEAP_UNITS];
  int unsigned  tag_sz  [HEAP_UNITS];
  bit           tag_us  [HEAP_UNITS];
  bit           touched [HEAP_UNITS];
  int unsigned  rov;
  int unsigned  top;
  int unsigned  page = PAGE_RESET;

  heap_answer_t answers_due[$];
  int unsigned  live_ptrs[$];
  int unsigned  stale_ptrs[$];
  int unsigned  errors = 0;
  int unsigned  src_idle = 36;
  int unsigned  snk_idle = 63;

  function automatic int unsigned wrap(input int unsigned a);
    return a % HEAP_UNITS;
  endfunction

  function automatic void put_tag(input int unsigned u, input int unsigned s, input bit f);
    int unsigned i;
    i = wrap(u);
    tag_sz[i]  = s;
    tag_us[i]  = f;
    touched[i] = 1'b1;
  endfunction

  function automatic void heap_clear();
    for (int i = 0; i < HEAP_UNITS; i++) begin
      link_nx[i] = 0;
      link_pv[i] = 0;
      tag_sz[i]  = 0;
      tag_us[i]  = 0;
      touched[i] = 0;
    end
    // Sentinel block at units 0 and 1, guard tag at unit 2.
    put_tag(0, SENTINEL_SZ, 1'b1);
    put_tag(1, SENTINEL_SZ, 1'b1);
    put_tag(2, 0, 1'b1);
    rov = 0;
    top = FIRST_BLOCK;
  endfunction

  function automatic bit is_used(input int unsigned u);
    if (u >= top) return 1'b1;
    return tag_us[wrap(u)];
  endfunction

  function automatic void unlink(input int unsigned b);
    int unsigned p, n;
    p = wrap(link_pv[wrap(b)]);
    n = wrap(link_nx[wrap(b)]);
    link_nx[p] = n;
    link_pv[n] = p;
    touched[p] = 1'b1;
    touched[n] = 1'b1;
  endfunction

  // Frees block b: joins the lower neighbor (which keeps its list place) or links b in after
  // the rover, then swallows a free upper neighbor. The rover ends on the merged block.
  function automatic void coalesce_free(input int unsigned b0);
    int unsigned b, n, after, old, s;
    b = wrap(b0);
    n = tag_sz[b];
    if (is_used(b - 1)) begin
      after = wrap(link_nx[wrap(rov)]);
      link_pv[b] = wrap(rov);
      link_nx[b] = after;
      link_pv[after] = b;
      link_nx[wrap(rov)] = b;
      touched[b] = 1'b1;
      touched[after] = 1'b1;
      touched[wrap(rov)] = 1'b1;
    end else begin
      old = b;
      put_tag(b - 1, tag_sz[wrap(b - 1)], 1'b0);
      b = wrap(b - tag_sz[wrap(b - 1)]);
      put_tag(old, tag_sz[old], 1'b0);
      n += tag_sz[b];
      put_tag(b, n, 1'b0);
      put_tag(b + n - 1, n, 1'b0);
    end
    if (!is_used(b + n)) begin
      s = wrap(b + n);
      unlink(s);
      put_tag(b + n - 1, n, 1'b0);
      put_tag(s, tag_sz[s], 1'b0);
      n += tag_sz[s];
    end
    put_tag(b, n, 1'b0);
    put_tag(b + n - 1, n, 1'b0);
    rov = b;
  endfunction

  function automatic bit extend_heap(input int unsigned need);
    int unsigned nu, b;
    nu = (need < page) ? page : need;
    if (top > HEAP_UNITS || nu > HEAP_UNITS - top) return 1'b0;
    b = top;
    put_tag(b, nu, 1'b1);
    put_tag(b + nu - 1, nu, 1'b1);
    top += nu;
    coalesce_free(b);
    return 1'b1;
  endfunction

  function automatic bit has_room(input int unsigned u, input int unsigned n);
    return !tag_us[wrap(u)] && tag_sz[wrap(u)] >= n;
  endfunction

  // Hands out n units of free block b: the whole block when fewer than two units would be
  // left over, else the tail end of it.
  function automatic int unsigned carve(input int unsigned b0, input int unsigned n);
    int unsigned b, s, r;
    b = b0;
    s = tag_sz[wrap(b)];
    if (s < n + MIN_SPLIT) begin
      tag_us[wrap(b)] = 1'b1;
      tag_us[wrap(b + s - 1)] = 1'b1;
      unlink(b);
    end else begin
      r = s - n;
      put_tag(b, r, 1'b0);
      put_tag(b + r - 1, r, 1'b0);
      b = wrap(b + r);
      put_tag(b, n, 1'b1);
      put_tag(b + n - 1, n, 1'b1);
    end
    if (rov == wrap(b)) rov = wrap(link_pv[wrap(b)]);
    return wrap(b);
  endfunction

  function automatic int unsigned need_units(input longint unsigned bytes);
    return int'((bytes + UNIT_BYTES - 1) / UNIT_BYTES + SENTINEL_SZ);
  endfunction

  // Next-fit search from the rover; grows the heap once when the walk wraps. 0 means no room.
  function automatic int unsigned find_block(input int unsigned n);
    int unsigned b;
    b = rov;
    for (int i = 0; i < HEAP_UNITS; i++) begin
      if (has_room(b, n)) return carve(b, n);
      b = wrap(link_nx[wrap(b)]);
      if (b == rov) break;
    end
    if (!extend_heap(n)) return 0;
    if (!has_room(rov, n)) return 0;
    return carve(rov, n);
  endfunction

  function automatic bit live_block(input int unsigned b);
    int unsigned s;
    if (b < FIRST_BLOCK || b >= top || !tag_us[wrap(b)]) return 1'b0;
    s = tag_sz[wrap(b)];
    if (s < 2 || s > top - b) return 1'b0;
    return tag_us[wrap(b + s - 1)] && tag_sz[wrap(b + s - 1)] == s;
  endfunction

  // Applies one request to the shadow heap and returns the answer the block owes for it.
  function automatic heap_answer_t predict_request(input logic [CMD_W-1:0] op,
                                                   input int unsigned sz, input int unsigned ad);
    heap_answer_t     r;
    int unsigned      b, os, u;
    longint unsigned  total, ob_bytes;
    r = '0;
    r.st = ST_OK;
    if (op == CMD_ALLOC || (op == CMD_REALLOC && ad == 0)) begin
      b = find_block(need_units(sz));
      if (b == 0) r.st = ST_OOM;
      else r.ra = ADDR_W'(b + 1);
    end else if (op == CMD_FREE) begin
      if (ad == 0 || !live_block(ad - 1)) r.st = ST_IGNORED;
      else coalesce_free(ad - 1);
    end else if (op == CMD_REALLOC) begin
      if (!live_block(ad - 1)) begin
        r.st = ST_IGNORED;
      end else if (sz > 0 && tag_sz[wrap(ad - 1)] >= need_units(sz)) begin
        r.ra = ADDR_W'(ad);
      end else begin
        os = tag_sz[wrap(ad - 1)];
        b = find_block(need_units(sz));
        if (b == 0) begin
          r.st = ST_OOM;
        end else begin
          ob_bytes = longint'(os - 2) * UNIT_BYTES;
          r.cp = BYTES_W'((ob_bytes < sz) ? ob_bytes : sz);
          coalesce_free(ad - 1);
          r.ra = ADDR_W'(b + 1);
        end
      end
    end else if (op == CMD_QUERY) begin
      total = 0;
      u = rov;
      for (int i = 0; i < HEAP_UNITS; i++) begin
        if (!tag_us[wrap(u)]) total += tag_sz[wrap(u)];
        u = wrap(link_nx[wrap(u)]);
        if (u == rov) break;
      end
      total *= UNIT_BYTES;
      r.fb = (total > 18'h3FFFF) ? 18'h3FFFF : BYTES_W'(total);
    end else if (op == CMD_REINIT) begin
      heap_clear();
    end
    return r;
  endfunction

  // A stale address is safe to free only if every tag the block will look at was written.
  function automatic bit stale_ok(input int unsigned a);
    int unsigned b, s;
    b = a - 1;
    if (b >= top) return 1'b1;
    if (!touched[b]) return 1'b0;
    if (!tag_us[b]) return 1'b1;
    s = tag_sz[b];
    if (s < 2 || s > top - b) return 1'b1;
    return touched[wrap(b + s - 1)];
  endfunction

  function automatic void drop_ptr(input int unsigned a);
    foreach (live_ptrs[i]) begin
      if (live_ptrs[i] == a) begin
        live_ptrs.delete(i);
        break;
      end
    end
    stale_ptrs.push_back(a);
    if (stale_ptrs.size() > 64) void'(stale_ptrs.pop_front());
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= PRINT_CAP) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // Offers one request, waits for it to be taken, predicts its answer and tracks pointers.
  task automatic send_request(input logic [CMD_W-1:0] op, input int unsigned sz,
                              input int unsigned ad, input bit typed,
                              input heap_answer_t typed_ans, output heap_answer_t r);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {2'b00, ad[ADDR_W-1:0], sz[BYTES_W-1:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    r = predict_request(op, sz, ad);
    answers_due.push_back(typed ? typed_ans : r);
    if (r.st == ST_OK) begin
      if (op == CMD_ALLOC || (op == CMD_REALLOC && ad == 0)) begin
        live_ptrs.push_back(r.ra);
      end else if (op == CMD_REALLOC && r.ra != ad) begin
        drop_ptr(ad);
        live_ptrs.push_back(r.ra);
      end else if (op == CMD_FREE) begin
        drop_ptr(ad);
      end else if (op == CMD_REINIT) begin
        live_ptrs.delete();
        stale_ptrs.delete();
      end
    end
    @(negedge clk_i);
  endtask

  // Lets every pending answer arrive, then keeps waiting so that the sequencer is idle.
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (answers_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // APB write of page_units followed by a read back; only done with the block idle.
  task automatic set_page_units(input int unsigned val);
    psel = 1'b1; pwrite = 1'b1; paddr = REG_PAGE_UNITS; pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0;
    page = val & 32'h1FFF;
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    if (prdata[12:0] != page[12:0])
      report_mismatch($sformatf("page_units reads %0d, wrote %0d", prdata[12:0], page));
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0;
  endtask

  function automatic int unsigned pick_size();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 80) return $urandom_range(256);
    if (p < 95) return $urandom_range(4000);
    if (p < 98) return $urandom_range(MAX_BYTES);
    return MAX_BYTES;
  endfunction

  // Mostly live pointers; otherwise null, the reserved low units, addresses past the heap
  // top, or pointers already given back.
  function automatic int unsigned pick_addr(input bit prefer_live);
    int unsigned p, a;
    if (prefer_live && live_ptrs.size() != 0 && $urandom_range(99) < 85)
      return live_ptrs[$urandom_range(live_ptrs.size() - 1)];
    p = $urandom_range(99);
    if (p < 20) return 0;
    if (p < 40) return $urandom_range(1, FIRST_BLOCK);
    if (p < 70 && top < HEAP_UNITS - 1) return $urandom_range(top + 1, HEAP_UNITS - 1);
    if (stale_ptrs.size() != 0) begin
      a = stale_ptrs[$urandom_range(stale_ptrs.size() - 1)];
      if (stale_ok(a)) return a;
    end
    return 0;
  endfunction

  task automatic random_requests(input int unsigned count);
    heap_answer_t     r;
    int unsigned      p;
    logic [CMD_W-1:0] op;
    int unsigned      sz, ad;
    for (int unsigned k = 0; k < count; k++) begin
      p = $urandom_range(99);
      sz = 0;
      ad = 0;
      if (p < 38) begin
        op = CMD_ALLOC;
        sz = pick_size();
      end else if (p < 64) begin
        op = CMD_FREE;
        ad = pick_addr(1'b1);
      end else if (p < 82) begin
        op = CMD_REALLOC;
        sz = pick_size();
        ad = pick_addr(1'b1);
      end else if (p < 90) begin
        op = CMD_QUERY;
      end else if (p < 91) begin
        op = CMD_REINIT;
      end else if (p < 94) begin
        // Spare codes with random payload: all fields must be ignored.
        op = $urandom_range(CMD_SPARE_LO, CMD_SPARE_HI);
        sz = $urandom_range(MAX_BYTES);
        ad = $urandom_range(HEAP_UNITS - 1);
      end else begin
        op = CMD_FREE;
        ad = pick_addr(1'b0);
      end
      send_request(op, sz, ad, 1'b0, '0, r);
      // Now and then the sender holds off until the block has answered everything.
      if (k % 150 == 149) drain();
    end
  endtask

  function automatic dir_row_t mk(input logic [CMD_W-1:0] op, input int unsigned sz,
                                  input int unsigned ad, input int unsigned back,
                                  input bit typed, input heap_answer_t ans);
    dir_row_t row;
    row.op = op; row.sz = sz; row.ad = ad; row.back = back; row.typed = typed; row.ans = ans;
    return row;
  endfunction

  // Receiver: stalls at random according to the current idling rate.
  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= snk_idle);

  // Answer checker: every accepted answer is compared with the oldest expectation.
  always @(posedge clk_i) begin
    heap_answer_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.ra = m_axis_tdata[11:0];
      got.st = m_axis_tdata[13:12];
      got.cp = m_axis_tdata[31:14];
      got.fb = m_axis_tdata[49:32];
      if (answers_due.size() == 0) begin
        report_mismatch("answer with no request outstanding");
      end else begin
        want = answers_due.pop_front();
        if (got.ra != want.ra)
          report_mismatch($sformatf("result_addr %0d, want %0d", got.ra, want.ra));
        if (got.st != want.st)
          report_mismatch($sformatf("status %0d, want %0d", got.st, want.st));
        if (got.cp != want.cp)
          report_mismatch($sformatf("copy_bytes %0d, want %0d", got.cp, want.cp));
        if (got.fb != want.fb)
          report_mismatch($sformatf("free_bytes %0d, want %0d", got.fb, want.fb));
      end
    end
  end

  // Watchdog: a long stretch with no handshake anywhere means the block has hung. The
  // longest legal silence is a heap reinitialize or a full list walk plus a growth.
  always @(posedge clk_i) begin
    int unsigned quiet;
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      quiet = 0;
    else
      quiet++;
    if (quiet >= STALL_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    dir_row_t     dir_tab[$];
    heap_answer_t row_ans[$];
    heap_answer_t r, zero_ans, ign_ans, oom_ans;
    int unsigned  ad;

    zero_ans = '0;
    ign_ans = '0;
    ign_ans.st = ST_IGNORED;
    oom_ans = '0;
    oom_ans.st = ST_OOM;

    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_ALLOC;
    m_axis_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = REG_PAGE_UNITS;
    pwdata = '0;
    heap_clear();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table. An empty heap reports no free bytes; a request for the largest size
    // needs more units than the store holds; a double free, a null free and frees of the
    // reserved or unused units are all ignored.
    dir_tab.push_back(mk(CMD_QUERY,   0,         0,    0, 1, zero_ans));
    dir_tab.push_back(mk(CMD_FREE,    0,         0,    0, 1, ign_ans));
    dir_tab.push_back(mk(CMD_FREE,    0,         4095, 0, 1, ign_ans));
    dir_tab.push_back(mk(CMD_ALLOC,   MAX_BYTES, 0,    0, 1, oom_ans));
    dir_tab.push_back(mk(CMD_SPARE_HI, 262143,   4095, 0, 1, zero_ans));
    dir_tab.push_back(mk(CMD_ALLOC,   0,         0,    0, 0, zero_ans));
    dir_tab.push_back(mk(CMD_ALLOC,   1,         0,    0, 0, zero_ans));
    dir_tab.push_back(mk(CMD_ALLOC,   32,        0,    0, 0, zero_ans));
    dir_tab.push_back(mk(CMD_ALLOC,   33,        0,    0, 0, zero_ans));
    // Null realloc behaves as an alloc.
    dir_tab.push_back(mk(CMD_REALLOC, 100,       0,    0, 0, zero_ans));
    // Realloc to a size that still fits keeps the block; realloc to zero bytes always moves.
    dir_tab.push_back(mk(CMD_REALLOC, 10,        0,    4, 0, zero_ans));
    dir_tab.push_back(mk(CMD_REALLOC, 0,         0,    6, 0, zero_ans));
    // Growing realloc past the free list forces a heap growth.
    dir_tab.push_back(mk(CMD_REALLOC, 8000,      0,    4, 0, zero_ans));
    dir_tab.push_back(mk(CMD_FREE,    0,         0,    6, 0, zero_ans));
    dir_tab.push_back(mk(CMD_FREE,    0,         0,    7, 1, ign_ans));
    dir_tab.push_back(mk(CMD_FREE,    0,         0,    6, 0, zero_ans));
    dir_tab.push_back(mk(CMD_QUERY,   0,         0,    0, 0, zero_ans));
    // Realloc that cannot be served keeps the old block.
    dir_tab.push_back(mk(CMD_REALLOC, MAX_BYTES, 0,    5, 1, oom_ans));
    dir_tab.push_back(mk(CMD_FREE,    0,         1,    0, 1, ign_ans));
    dir_tab.push_back(mk(CMD_ALLOC,   4000,      0,    0, 0, zero_ans));
    dir_tab.push_back(mk(CMD_QUERY,   0,         0,    0, 0, zero_ans));
    dir_tab.push_back(mk(CMD_REINIT,  0,         0,    0, 1, zero_ans));
    dir_tab.push_back(mk(CMD_QUERY,   0,         0,    0, 1, zero_ans));

    foreach (dir_tab[i]) begin
      ad = (dir_tab[i].back != 0) ? row_ans[i - dir_tab[i].back].ra : dir_tab[i].ad;
      send_request(dir_tab[i].op, dir_tab[i].sz, ad, dir_tab[i].typed, dir_tab[i].ans, r);
      row_ans.push_back(r);
    end
    drain();

    // Random phases, each under its own growth step and idling mix.
    set_page_units(1);
    random_requests(PHASE_REQS);
    drain();

    src_idle = 63;
    snk_idle = 36;
    set_page_units(HEAP_UNITS);
    random_requests(PHASE_REQS);
    drain();

    src_idle = 0;
    snk_idle = 0;
    set_page_units($urandom_range(1, 300));
    random_requests(PHASE_REQS);
    drain();

    if (answers_due.size() != 0)
      report_mismatch($sformatf("%0d answers never arrived", answers_due.size()));
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
